>>> rtl/lcdws_pkg.sv
package lcdws_pkg;

  localparam logic [2:0] FUNC_TICK = 3'd0;
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_INIT = 3'd1;
  localparam logic [2:0] KIND_CLEAR = 3'd2;
  localparam logic [2:0] KIND_ADJ = 3'd3;
  localparam logic [2:0] KIND_RAW = 3'd4;
  localparam logic [2:0] KIND_ADDR = 3'd5;
  localparam logic [2:0] KIND_PWAIT = 3'd6;
  localparam logic [2:0] KIND_GAP = 3'd7;

  localparam logic [1:0] REG_POWER_ON_WAIT = 2'd0;
  localparam logic [1:0] REG_INIT_GAP = 2'd1;
  localparam logic [1:0] REG_PULSE = 2'd2;

  localparam logic [7:0] POWER_ON_WAIT_RESET = 8'd15;
  localparam logic [7:0] INIT_GAP_RESET = 8'd5;
  localparam logic [7:0] PULSE_RESET = 8'd1;

  localparam logic [7:0] ADJ_LIMIT = 8'd20;

  localparam logic [3:0] INIT_LEN = 4'd9;
  localparam logic [3:0] CLEAR_LEN = 4'd4;
  localparam logic [3:0] CHAR_LEN = 4'd2;

  typedef logic [3:0] nibble_t;

  localparam nibble_t INIT_NIBBLES [0:8] = '{
    4'b0010, 4'b0010, 4'b1000, 4'b0000, 4'b1111, 4'b0000, 4'b0001, 4'b0000, 4'b0110
  };
  localparam nibble_t CLEAR_NIBBLES [0:3] = '{4'b0000, 4'b0001, 4'b1000, 4'b0000};

  typedef struct packed {
    logic [7:0] power_on_wait;
    logic [7:0] init_gap;
    logic [7:0] pulse;
  } cfg_t;

  typedef struct packed {
    logic       busy;
    logic [2:0] kind;
    logic [7:0] held;
    logic [3:0] step;
    logic [7:0] wait_cnt;
    logic       en;
    logic       rs;
    nibble_t    nib;
  } seq_state_t;

  function automatic logic [3:0] nibble_count(input logic [2:0] kind);
    logic [3:0] n;
    case (kind)
      KIND_INIT: n = INIT_LEN;
      KIND_CLEAR: n = CLEAR_LEN;
      KIND_ADJ, KIND_RAW, KIND_ADDR: n = CHAR_LEN;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/lcd_4bit_write_sequencer_core.sv
// Four-bit character LCD write sequencer. Each input request carries a function in in_tuser
// (tick, init, clear, adjusted character, raw character, set address) and a value in
// in_tdata, and yields exactly one result with the EN, RS and data pin levels after the
// request, the busy flag and a flag that marks a command dropped because a sequence was
// still running. Time advances only on tick requests, one per millisecond. A request is
// taken into an input register and processed combinationally into the output register,
// so one request is accepted every clock while the result side keeps up. The three timing
// registers are written through the cfg_ port; the user must do so only while the block is
// idle, which the block itself does not enforce.
module lcd_4bit_write_sequencer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] value
  input  logic [2:0] in_tuser,   // [2:0] func
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] en_pin, [1] rs_pin, [5:2] data_nibble, [6] busy_res,
                                 // [7] rejected
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_wdata
);

  lcdws_pkg::cfg_t       cfg_r;
  lcdws_pkg::seq_state_t state_r;
  lcdws_pkg::seq_state_t state_nxt;
  logic                  in_valid_r;
  logic [2:0]            func_r;
  logic [7:0]            value_r;
  logic                  out_valid_r;
  logic [7:0]            out_data_r;
  logic                  rejected_nxt;
  logic                  advance;

  assign advance = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  lcdws_step u_step (
    .cfg      (cfg_r),
    .cur      (state_r),
    .func     (func_r),
    .value    (value_r),
    .nxt      (state_nxt),
    .rejected (rejected_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_on_wait <= lcdws_pkg::POWER_ON_WAIT_RESET;
      cfg_r.init_gap <= lcdws_pkg::INIT_GAP_RESET;
      cfg_r.pulse <= lcdws_pkg::PULSE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        lcdws_pkg::REG_POWER_ON_WAIT: cfg_r.power_on_wait <= cfg_wdata;
        lcdws_pkg::REG_INIT_GAP: cfg_r.init_gap <= cfg_wdata;
        lcdws_pkg::REG_PULSE: cfg_r.pulse <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= in_tuser;
      value_r <= in_tdata;
    end
    if (advance) begin
      out_data_r <= {rejected_nxt, state_nxt.busy, state_nxt.nib, state_nxt.rs, state_nxt.en};
    end
  end

endmodule

>>> rtl/lcdws_step.sv
module lcdws_step (
  input  lcdws_pkg::cfg_t       cfg,
  input  lcdws_pkg::seq_state_t cur,
  input  logic [2:0]            func,
  input  logic [7:0]            value,
  output lcdws_pkg::seq_state_t nxt,
  output logic                  rejected
);

  logic [7:0] pulse_load;
  assign pulse_load = (cfg.pulse == 8'd0) ? 8'd1 : cfg.pulse;

  function automatic lcdws_pkg::seq_state_t start_nibble(
    input lcdws_pkg::seq_state_t s,
    input logic [7:0]            pl
  );
    lcdws_pkg::seq_state_t r;
    r = s;
    r.rs = 1'b0;
    r.nib = 4'd0;
    case (s.kind)
      lcdws_pkg::KIND_INIT: begin
        r.nib = lcdws_pkg::INIT_NIBBLES[(s.step < lcdws_pkg::INIT_LEN) ? s.step : 4'd8];
      end
      lcdws_pkg::KIND_CLEAR: begin
        r.nib = lcdws_pkg::CLEAR_NIBBLES[s.step[1:0]];
      end
      lcdws_pkg::KIND_ADJ, lcdws_pkg::KIND_RAW: begin
        r.nib = (s.step == 4'd0) ? s.held[7:4] : s.held[3:0];
        r.rs = 1'b1;
      end
      lcdws_pkg::KIND_ADDR: begin
        r.nib = (s.step == 4'd0) ? {1'b1, s.held[6:4]} : s.held[3:0];
      end
      default: begin
        r.nib = 4'd0;
      end
    endcase
    r.en = 1'b1;
    r.wait_cnt = pl;
    return r;
  endfunction

  always_comb begin
    logic [7:0] w1;
    nxt = cur;
    rejected = 1'b0;
    w1 = (cur.wait_cnt != 8'd0) ? cur.wait_cnt - 8'd1 : 8'd0;
    if (func == lcdws_pkg::FUNC_TICK) begin
      if (cur.busy) begin
        nxt.wait_cnt = w1;
        if (w1 == 8'd0) begin
          if (cur.kind == lcdws_pkg::KIND_PWAIT) begin
            nxt.kind = lcdws_pkg::KIND_INIT;
            nxt.step = 4'd0;
            nxt = start_nibble(nxt, pulse_load);
          end else if (cur.kind == lcdws_pkg::KIND_GAP) begin
            nxt.kind = lcdws_pkg::KIND_INIT;
            nxt.step = 4'd1;
            nxt = start_nibble(nxt, pulse_load);
          end else if (cur.en) begin
            nxt.en = 1'b0;
            nxt.wait_cnt = pulse_load;
          end else if (cur.kind == lcdws_pkg::KIND_INIT && cur.step == 4'd0) begin
            if (cfg.init_gap == 8'd0) begin
              nxt.step = 4'd1;
              nxt = start_nibble(nxt, pulse_load);
            end else begin
              nxt.kind = lcdws_pkg::KIND_GAP;
              nxt.wait_cnt = cfg.init_gap;
            end
          end else begin
            nxt.step = cur.step + 4'd1;
            if (nxt.step < lcdws_pkg::nibble_count(cur.kind)) begin
              nxt = start_nibble(nxt, pulse_load);
            end else begin
              nxt.busy = 1'b0;
            end
          end
        end
      end
    end else if (func <= lcdws_pkg::KIND_ADDR) begin
      if (cur.busy) begin
        rejected = 1'b1;
      end else begin
        nxt.busy = 1'b1;
        nxt.step = 4'd0;
        if (func == lcdws_pkg::KIND_INIT) begin
          nxt.held = 8'd0;
          if (cfg.power_on_wait == 8'd0) begin
            nxt.kind = lcdws_pkg::KIND_INIT;
            nxt = start_nibble(nxt, pulse_load);
          end else begin
            nxt.kind = lcdws_pkg::KIND_PWAIT;
            nxt.wait_cnt = cfg.power_on_wait;
            nxt.en = 1'b0;
          end
        end else begin
          nxt.kind = func;
          if (func == lcdws_pkg::KIND_CLEAR) begin
            nxt.held = 8'd0;
          end else if (func == lcdws_pkg::KIND_ADJ && value < lcdws_pkg::ADJ_LIMIT) begin
            nxt.held = value - 8'd1;
          end else begin
            nxt.held = value;
          end
          nxt = start_nibble(nxt, pulse_load);
        end
      end
    end
  end

endmodule

>>> dv/lcd_pin_checker.sv
`timescale 1ns / 1ps

module lcd_pin_checker
  import lcdws_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] value
  input  logic [2:0] in_tuser,   // [2:0] func
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [0] en_pin, [1] rs_pin, [5:2] data_nibble, [6] busy_res,
                                 // [7] rejected
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_wdata,
  output int         mismatches,
  output int         outstanding,
  output logic       seq_busy
);

  typedef struct packed {
    logic    rejected;
    logic    busy;
    nibble_t nib;
    logic    rs;
    logic    en;
  } pins_t;

  localparam nibble_t POWER_UP_SEQ [0:8] = '{
    4'h2, 4'h2, 4'h8, 4'h0, 4'hF, 4'h0, 4'h1, 4'h0, 4'h6
  };
  localparam nibble_t CLEAR_SEQ [0:3] = '{4'h0, 4'h1, 4'h8, 4'h0};

  cfg_t       timing;
  seq_state_t seq;
  pins_t      pin_queue [$];

  function automatic logic [7:0] pulse_ticks();
    return (timing.pulse == 8'd0) ? 8'd1 : timing.pulse;
  endfunction

  function automatic logic [3:0] seq_length(input logic [2:0] kind);
    case (kind)
      KIND_INIT: return 4'd9;
      KIND_CLEAR: return 4'd4;
      KIND_ADJ, KIND_RAW, KIND_ADDR: return 4'd2;
      default: return 4'd0;
    endcase
  endfunction

  function automatic void raise_enable();
    seq.rs = 1'b0;
    case (seq.kind)
      KIND_INIT: seq.nib = POWER_UP_SEQ[(seq.step < 4'd9) ? seq.step : 4'd8];
      KIND_CLEAR: seq.nib = CLEAR_SEQ[seq.step[1:0]];
      KIND_ADJ, KIND_RAW: begin
        seq.nib = (seq.step == 4'd0) ? seq.held[7:4] : seq.held[3:0];
        seq.rs = 1'b1;
      end
      KIND_ADDR: seq.nib = (seq.step == 4'd0) ? {1'b1, seq.held[6:4]} : seq.held[3:0];
      default: seq.nib = 4'd0;
    endcase
    seq.en = 1'b1;
    seq.wait_cnt = pulse_ticks();
  endfunction

  function automatic void advance_millisecond();
    if (!seq.busy) return;
    if (seq.wait_cnt != 8'd0) seq.wait_cnt = seq.wait_cnt - 8'd1;
    if (seq.wait_cnt != 8'd0) return;
    if (seq.kind == KIND_PWAIT) begin
      seq.kind = KIND_INIT;
      seq.step = 4'd0;
      raise_enable();
    end else if (seq.kind == KIND_GAP) begin
      seq.kind = KIND_INIT;
      seq.step = 4'd1;
      raise_enable();
    end else if (seq.en) begin
      seq.en = 1'b0;
      seq.wait_cnt = pulse_ticks();
    end else if (seq.kind == KIND_INIT && seq.step == 4'd0) begin
      if (timing.init_gap == 8'd0) begin
        seq.step = 4'd1;
        raise_enable();
      end else begin
        seq.kind = KIND_GAP;
        seq.wait_cnt = timing.init_gap;
      end
    end else begin
      seq.step = seq.step + 4'd1;
      if (seq.step < seq_length(seq.kind)) raise_enable();
      else seq.busy = 1'b0;
    end
  endfunction

  function automatic pins_t take_request(input logic [2:0] func, input logic [7:0] value);
    pins_t r;
    logic  dropped;
    dropped = 1'b0;
    if (func == FUNC_TICK) begin
      advance_millisecond();
    end else if (func <= KIND_ADDR) begin
      if (seq.busy) begin
        dropped = 1'b1;
      end else begin
        seq.busy = 1'b1;
        seq.step = 4'd0;
        if (func == KIND_INIT) begin
          seq.held = 8'd0;
          if (timing.power_on_wait == 8'd0) begin
            seq.kind = KIND_INIT;
            raise_enable();
          end else begin
            seq.kind = KIND_PWAIT;
            seq.wait_cnt = timing.power_on_wait;
            seq.en = 1'b0;
          end
        end else begin
          seq.kind = func;
          if (func == KIND_CLEAR) seq.held = 8'd0;
          else if (func == KIND_ADJ && value < ADJ_LIMIT) seq.held = value - 8'd1;
          else seq.held = value;
          raise_enable();
        end
      end
    end
    r.en = seq.en;
    r.rs = seq.rs;
    r.nib = seq.nib;
    r.busy = seq.busy;
    r.rejected = dropped;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    pins_t want;
    pins_t got;
    if (!rst_n) begin
      timing = {POWER_ON_WAIT_RESET, INIT_GAP_RESET, PULSE_RESET};
      seq = '0;
      pin_queue.delete();
      mismatches = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pin_queue.size() == 0) begin
          $error("result %h arrived with no request outstanding", out_tdata);
          mismatches++;
        end else begin
          want = pin_queue.pop_front();
          check_field("en_pin", 4'(want.en), 4'(got.en));
          check_field("rs_pin", 4'(want.rs), 4'(got.rs));
          check_field("data_nibble", want.nib, got.nib);
          check_field("busy_res", 4'(want.busy), 4'(got.busy));
          check_field("rejected", 4'(want.rejected), 4'(got.rejected));
        end
      end
      if (in_tvalid && in_tready) pin_queue.push_back(take_request(in_tuser, in_tdata));
      if (cfg_we) begin
        case (cfg_addr)
          REG_POWER_ON_WAIT: timing.power_on_wait = cfg_wdata;
          REG_INIT_GAP: timing.init_gap = cfg_wdata;
          REG_PULSE: timing.pulse = cfg_wdata;
          default: ;
        endcase
      end
    end
    outstanding = pin_queue.size();
    seq_busy = seq.busy;
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lcdws_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TOTAL_ITEMS = 1850;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] value
  logic [2:0] in_tuser;   // [2:0] func
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [0] en_pin, [1] rs_pin, [5:2] data_nibble, [6] busy_res,
                          // [7] rejected
  logic       cfg_we;
  logic [1:0] cfg_addr;
  logic [7:0] cfg_wdata;

  int   mismatches;
  int   outstanding;
  logic seq_busy;
  bit   calm;
  int   items_sent;
  int   cycles;

  lcd_4bit_write_sequencer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  lcd_pin_checker u_pin_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .seq_busy   (seq_busy)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    @(negedge clk);
    forever begin : drain
      int stall;
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_request(input logic [2:0] func, input logic [7:0] value);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= value;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic tick_until_idle();
    while (seq_busy) send_request(FUNC_TICK, 8'($urandom));
  endtask

  task automatic run_command(input logic [2:0] func, input logic [7:0] value);
    send_request(func, value);
    tick_until_idle();
  endtask

  task automatic program_timing(input logic [7:0] power_on, input logic [7:0] gap,
                                input logic [7:0] pulse);
    tick_until_idle();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_POWER_ON_WAIT;
    cfg_wdata <= power_on;
    @(negedge clk);
    cfg_addr <= REG_INIT_GAP;
    cfg_wdata <= gap;
    @(negedge clk);
    cfg_addr <= REG_PULSE;
    cfg_wdata <= pulse;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int quota);
    int          start;
    int          pick;
    logic [2:0]  func;
    start = items_sent;
    while (items_sent - start < quota) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        func = ($urandom_range(0, 5) == 0) ? KIND_INIT : 3'($urandom_range(2, 5));
        send_request(func, 8'($urandom));
        while (seq_busy) begin
          if ($urandom_range(0, 19) == 0) break;
          if ($urandom_range(0, 9) == 0) send_request(3'($urandom), 8'($urandom));
          else send_request(FUNC_TICK, 8'($urandom));
        end
      end else if (pick < 9) begin
        send_request(3'($urandom), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 5)) send_request(FUNC_TICK, 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_tuser = FUNC_TICK;
    cfg_we = 1'b0;
    cfg_addr = REG_POWER_ON_WAIT;
    cfg_wdata = 8'd0;
    calm = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(FUNC_TICK, 8'hFF);
    send_request(KIND_INIT, 8'h00);
    send_request(KIND_RAW, 8'h41);
    send_request(KIND_GAP, 8'h12);
    tick_until_idle();
    send_request(KIND_PWAIT, 8'hFF);
    send_request(FUNC_TICK, 8'h00);
    run_command(KIND_ADJ, 8'd0);
    run_command(KIND_ADJ, 8'd19);
    run_command(KIND_ADJ, 8'd20);
    run_command(KIND_ADJ, 8'd128);
    run_command(KIND_ADJ, 8'd255);
    run_command(KIND_RAW, 8'h00);
    run_command(KIND_RAW, 8'hFF);
    run_command(KIND_ADDR, 8'h00);
    run_command(KIND_ADDR, 8'h7F);
    run_command(KIND_ADDR, 8'h80);
    run_command(KIND_CLEAR, 8'hA5);

    program_timing(8'd0, 8'd0, 8'd0);
    run_command(KIND_INIT, 8'h5A);
    program_timing(8'd255, 8'd255, 8'd1);
    run_command(KIND_INIT, 8'h00);
    program_timing(8'd3, 8'd2, 8'd255);
    run_command(KIND_RAW, 8'h5A);

    while (items_sent < TOTAL_ITEMS) begin
      program_timing(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 30)),
                     ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 10)),
                     8'($urandom_range(0, 4)));
      calm = ($urandom_range(0, 3) == 0);
      random_phase(150);
    end
    calm = 1'b0;

    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lcdws_pkg.sv
rtl/lcdws_step.sv
rtl/lcd_4bit_write_sequencer_core.sv
dv/lcd_pin_checker.sv
dv/testbench.sv
